// ===== rtl/asdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the difficulty target pipeline.
package asdt_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_POW_W0  = 3'd0;
    localparam logic [2:0] CFG_POW_W1  = 3'd1;
    localparam logic [2:0] CFG_POW_W2  = 3'd2;
    localparam logic [2:0] CFG_POW_W3  = 3'd3;
    localparam logic [2:0] CFG_SPACING = 3'd4;
    localparam logic [2:0] CFG_HLIFE   = 3'd5;

    // Divider: 62-bit dividend, two quotient bits per stage
    localparam int DIV_BITS   = 62;
    localparam int DIV_STAGES = DIV_BITS / 2;

    // Accept edge to result edge
    localparam int LATENCY = DIV_STAGES + 12;

    // Cubic 2^x approximation coefficients
    localparam logic [47:0] POLY_A   = 48'd195766423245049;
    localparam logic [29:0] POLY_B   = 30'd971821376;
    localparam logic [12:0] POLY_C   = 13'd5127;
    localparam logic [63:0] POLY_RND = 64'h0000_8000_0000_0000;

    // Drift clamp, 2^44
    localparam logic [44:0] DRIFT_LIMIT = 45'h1000_0000_0000;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_div_ctl;

endpackage

// ===== rtl/asert_difficulty_target_top.sv =====
`timescale 1ns / 1ps
// Top level of the exponential difficulty target pipeline.
//
// Usage:
//   Input transaction: drive the reference target words, time_diff and
//   height_diff with start high; it is taken at any edge where busy is low.
//   busy is high during reset and for the first edge after reset is released;
//   after that a new transaction may enter every cycle.
//   Result transaction: o_valid is high for exactly one cycle together with
//   the next target words and o_input_error. The receiver cannot stall.
//   A result passes through 31 divider stages plus 12 other stages.
//   Throughput: one per cycle.
//   The rate is set by the fully pipelined 62-bit divider (two quotient bits
//   per stage), the staged cubic polynomial and the 256x17 multiply, which is
//   cut into eight 32x17 partial products.
//   Configuration: a write with i_cfg_we high lands at that edge; do it only
//   while no transaction is in flight. Indexes above 5 are ignored.
//   Reset (synchronous, active low) clears all valid bits and restores the
//   default pow limit (2^224-1), spacing 600 and half life 172800.
module asert_difficulty_target_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [63:0]         i_ref_target_w0,
    input  logic [63:0]         i_ref_target_w1,
    input  logic [63:0]         i_ref_target_w2,
    input  logic [63:0]         i_ref_target_w3,
    input  logic signed [32:0]  i_time_diff,
    input  logic [31:0]         i_height_diff,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [63:0]         i_cfg_data,
    output logic                o_valid,
    output logic [63:0]         o_next_target_w0,
    output logic [63:0]         o_next_target_w1,
    output logic [63:0]         o_next_target_w2,
    output logic [63:0]         o_next_target_w3,
    output logic                o_input_error
);

    typedef struct packed {
        logic         err;
        logic         sat_big;
        logic         tiny;
        logic [9:0]   k;
        logic [255:0] tgt;
    } t_side;

    // ---------------- configuration ----------------
    logic [255:0] r_pow_limit;
    logic [19:0]  r_spacing;
    logic [31:0]  r_hlife;
    logic         r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pow_limit <= {32'd0, {224{1'b1}}};
            r_spacing   <= 20'd600;
            r_hlife     <= 32'd172800;
            r_busy      <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    asdt_pkg::CFG_POW_W0:  r_pow_limit[63:0]    <= i_cfg_data;
                    asdt_pkg::CFG_POW_W1:  r_pow_limit[127:64]  <= i_cfg_data;
                    asdt_pkg::CFG_POW_W2:  r_pow_limit[191:128] <= i_cfg_data;
                    asdt_pkg::CFG_POW_W3:  r_pow_limit[255:192] <= i_cfg_data;
                    asdt_pkg::CFG_SPACING: r_spacing <= i_cfg_data[19:0];
                    asdt_pkg::CFG_HLIFE:   r_hlife   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // ---------------- stage 1: spacing product, precondition check ----------------
    logic         r1_valid;
    logic [255:0] r1_tgt;
    logic [32:0]  r1_t;
    logic [52:0]  r1_prod;
    logic         r1_err;
    logic [255:0] in_tgt;
    logic [32:0]  hp1;

    assign in_tgt = {i_ref_target_w3, i_ref_target_w2, i_ref_target_w1, i_ref_target_w0};
    assign hp1    = {1'b0, i_height_diff} + 33'd1;

    always_ff @(posedge i_clk) begin
        r1_valid <= i_rst_n && start && !r_busy;
        r1_tgt   <= in_tgt;
        r1_t     <= i_time_diff;
        r1_prod  <= {33'd0, r_spacing} * {20'd0, hp1};
        r1_err   <= (in_tgt == '0) || (in_tgt > r_pow_limit) || (r_hlife == '0);
    end

    // ---------------- stage 2: drift and clamp ----------------
    logic         r2_valid;
    logic [255:0] r2_tgt;
    logic         r2_err;
    logic         r2_neg;
    logic [44:0]  r2_mag;
    logic [54:0]  drift;
    logic [54:0]  drift_abs;

    assign drift     = {{22{r1_t[32]}}, r1_t} - {2'd0, r1_prod};
    assign drift_abs = drift[54] ? (55'd0 - drift) : drift;

    always_ff @(posedge i_clk) begin
        r2_valid <= i_rst_n && r1_valid;
        r2_tgt   <= r1_tgt;
        r2_err   <= r1_err;
        r2_neg   <= drift[54];
        if (drift_abs > {10'd0, asdt_pkg::DRIFT_LIMIT}) begin
            r2_mag <= asdt_pkg::DRIFT_LIMIT;
        end else begin
            r2_mag <= drift_abs[44:0];
        end
    end

    // ---------------- divider: |drift| * 65536 / half life ----------------
    asdt_pkg::t_div_ctl                div_in;
    asdt_pkg::t_div_ctl                div_out;
    logic [asdt_pkg::DIV_BITS-1:0]     quot;
    logic [255:0]                      r_dtgt [asdt_pkg::DIV_STAGES];
    logic                              r_derr [asdt_pkg::DIV_STAGES];

    assign div_in.valid = r2_valid;
    assign div_in.neg   = r2_neg;

    asdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in),
        .i_num   ({1'b0, r2_mag, 16'd0}),
        .i_den   (r_hlife),
        .o_ctl   (div_out),
        .o_quot  (quot)
    );

    // target and error ride alongside the divider
    always_ff @(posedge i_clk) begin
        r_dtgt[0] <= r2_tgt;
        r_derr[0] <= r2_err;
        for (int g = 1; g < asdt_pkg::DIV_STAGES; g++) begin
            r_dtgt[g] <= r_dtgt[g-1];
            r_derr[g] <= r_derr[g-1];
        end
    end

    // ---------------- stage 3: split exponent into shift and fraction ----------------
    logic        r3_valid;
    t_side       r3_sd;
    logic [15:0] r3_frac;
    logic [62:0] expo;
    logic [47:0] sh_amt;
    logic [47:0] kk;

    assign expo   = div_out.neg ? (63'd0 - {1'b0, quot}) : {1'b0, quot};
    // floor(expo / 65536) - 16
    assign sh_amt = {expo[62], expo[62:16]} - 48'd16;
    assign kk     = 48'd256 - sh_amt;

    always_ff @(posedge i_clk) begin
        r3_valid      <= i_rst_n && div_out.valid;
        r3_frac       <= expo[15:0];
        r3_sd.err     <= r_derr[asdt_pkg::DIV_STAGES-1];
        r3_sd.tgt     <= r_dtgt[asdt_pkg::DIV_STAGES-1];
        r3_sd.sat_big <= $signed(sh_amt) > 48'sd256;
        r3_sd.tiny    <= $signed(sh_amt) < -48'sd272;
        r3_sd.k       <= kk[9:0];
    end

    // ---------------- stages 4-7: cubic factor ----------------
    logic        r4_valid, r5_valid, r6_valid, r7_valid;
    t_side       r4_sd, r5_sd, r6_sd, r7_sd;
    logic [15:0] r4_f;
    logic [63:0] r4_af, r5_af, r5_bff, r6_cfff, r6_sab;
    logic [31:0] r4_ff;
    logic [47:0] r5_fff;
    logic [16:0] r7_factor;
    logic [63:0] poly_sum;

    assign poly_sum = r6_sab + r6_cfff + asdt_pkg::POLY_RND;

    always_ff @(posedge i_clk) begin
        r4_valid  <= i_rst_n && r3_valid;
        r4_sd     <= r3_sd;
        r4_f      <= r3_frac;
        r4_af     <= {16'd0, asdt_pkg::POLY_A} * {48'd0, r3_frac};
        r4_ff     <= {16'd0, r3_frac} * {16'd0, r3_frac};

        r5_valid  <= i_rst_n && r4_valid;
        r5_sd     <= r4_sd;
        r5_af     <= r4_af;
        r5_bff    <= {34'd0, asdt_pkg::POLY_B} * {32'd0, r4_ff};
        r5_fff    <= {16'd0, r4_ff} * {32'd0, r4_f};

        r6_valid  <= i_rst_n && r5_valid;
        r6_sd     <= r5_sd;
        r6_cfff   <= {51'd0, asdt_pkg::POLY_C} * {16'd0, r5_fff};
        r6_sab    <= r5_af + r5_bff;

        r7_valid  <= i_rst_n && r6_valid;
        r7_sd     <= r6_sd;
        r7_factor <= 17'h10000 + {1'b0, poly_sum[63:48]};
    end

    // ---------------- stages 8-9: target times factor ----------------
    logic        r8_valid, r9_valid;
    t_side       r8_sd, r9_sd;
    logic [48:0] r8_pp [8];
    logic [272:0] r9_v;
    logic [255:0] pp_even;
    logic [255:0] pp_odd;

    assign pp_even = {15'd0, r8_pp[6], 15'd0, r8_pp[4], 15'd0, r8_pp[2], 15'd0, r8_pp[0]};
    assign pp_odd  = {15'd0, r8_pp[7], 15'd0, r8_pp[5], 15'd0, r8_pp[3], 15'd0, r8_pp[1]};

    always_ff @(posedge i_clk) begin
        r8_valid <= i_rst_n && r7_valid;
        r8_sd    <= r7_sd;
        for (int j = 0; j < 8; j++) begin
            r8_pp[j] <= {17'd0, r7_sd.tgt[32*j +: 32]} * {32'd0, r7_factor};
        end
        r9_valid <= i_rst_n && r8_valid;
        r9_sd    <= r8_sd;
        r9_v     <= {17'd0, pp_even} + {pp_odd[240:0], 32'd0};
    end

    // ---------------- stages 10-11: shift by k = 256 - s ----------------
    logic         r10_valid, r11_valid;
    t_side        r10_sd, r11_sd;
    logic [528:0] r10_w, r11_w;

    always_ff @(posedge i_clk) begin
        r10_valid <= i_rst_n && r9_valid;
        r10_sd    <= r9_sd;
        r10_w     <= {r9_v, 256'd0} >> {r9_sd.k[9:5], 5'd0};
        r11_valid <= i_rst_n && r10_valid;
        r11_sd    <= r10_sd;
        r11_w     <= r10_w >> r10_sd.k[4:0];
    end

    // ---------------- stage 12: saturate, floor at one, output ----------------
    logic [255:0] res;
    logic         over;
    logic [255:0] fin;
    logic [255:0] r_out;
    logic         r_out_err;
    logic         r_out_valid;

    assign over = !r11_sd.tiny && (r11_sd.sat_big || (r11_w[528:256] != '0));
    assign res  = r11_sd.tiny ? 256'd0 : r11_w[255:0];

    always_comb begin
        if (r11_sd.err) begin
            fin = '0;
        end else if (over) begin
            fin = r_pow_limit;
        end else if (res == '0) begin
            fin = 256'd1;
        end else if (res > r_pow_limit) begin
            fin = r_pow_limit;
        end else begin
            fin = res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_valid <= i_rst_n && r11_valid;
        r_out       <= fin;
        r_out_err   <= r11_sd.err;
    end

    assign o_valid          = r_out_valid;
    assign o_next_target_w0 = r_out[63:0];
    assign o_next_target_w1 = r_out[127:64];
    assign o_next_target_w2 = r_out[191:128];
    assign o_next_target_w3 = r_out[255:192];
    assign o_input_error    = r_out_err;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, asdt_pkg::LATENCY))
        else $error("result without a matching start");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start && !busy, asdt_pkg::LATENCY) && $past(i_rst_n, asdt_pkg::LATENCY)
        |-> o_valid)
        else $error("accepted transaction produced no result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_input_error |-> (o_next_target_w0 == '0) && (o_next_target_w1 == '0)
            && (o_next_target_w2 == '0) && (o_next_target_w3 == '0))
        else $error("error result carries a nonzero target");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_input_error |-> (o_next_target_w0 != '0) || (o_next_target_w1 != '0)
            || (o_next_target_w2 != '0) || (o_next_target_w3 != '0))
        else $error("valid result target is zero");

endmodule

// ===== rtl/asdt_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, two quotient bits per stage.
module asdt_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  asdt_pkg::t_div_ctl                 i_ctl,
    input  logic [asdt_pkg::DIV_BITS-1:0]      i_num,
    input  logic [31:0]                        i_den,
    output asdt_pkg::t_div_ctl                 o_ctl,
    output logic [asdt_pkg::DIV_BITS-1:0]      o_quot
);

    asdt_pkg::t_div_ctl                r_ctl [asdt_pkg::DIV_STAGES];
    logic [31:0]                       r_rem [asdt_pkg::DIV_STAGES];
    logic [asdt_pkg::DIV_BITS-1:0]     r_num [asdt_pkg::DIV_STAGES];

    // num shifts out dividend bits at the top and takes quotient bits at the bottom
    function automatic logic [asdt_pkg::DIV_BITS+31:0] step2(
        input logic [31:0]                   rem,
        input logic [asdt_pkg::DIV_BITS-1:0] num,
        input logic [31:0]                   den
    );
        logic [32:0]                   t;
        logic [31:0]                   r;
        logic [asdt_pkg::DIV_BITS-1:0] n;
        r = rem;
        n = num;
        for (int i = 0; i < 2; i++) begin
            t = {r, n[asdt_pkg::DIV_BITS-1]};
            n = {n[asdt_pkg::DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                n[0] = 1'b1;
            end
            r = t[31:0];
        end
        return {r, n};
    endfunction

    always_ff @(posedge i_clk) begin
        logic [asdt_pkg::DIV_BITS+31:0] nx;
        for (int g = 0; g < asdt_pkg::DIV_STAGES; g++) begin
            if (g == 0) begin
                nx = step2(32'd0, i_num, i_den);
            end else begin
                nx = step2(r_rem[g-1], r_num[g-1], i_den);
            end
            r_rem[g] <= nx[asdt_pkg::DIV_BITS+31:asdt_pkg::DIV_BITS];
            r_num[g] <= nx[asdt_pkg::DIV_BITS-1:0];
        end
        if (!i_rst_n) begin
            for (int g = 0; g < asdt_pkg::DIV_STAGES; g++) begin
                r_ctl[g] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int g = 1; g < asdt_pkg::DIV_STAGES; g++) begin
                r_ctl[g] <= r_ctl[g-1];
            end
        end
    end

    assign o_ctl  = r_ctl[asdt_pkg::DIV_STAGES-1];
    assign o_quot = r_num[asdt_pkg::DIV_STAGES-1];

endmodule

// ===== dv/asert_difficulty_target_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the difficulty target pipeline.
module asert_difficulty_target_top_tb;

    // Indexes that no register answers to; writes there must be dropped
    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [63:0] K_A   = 64'd195766423245049;
    localparam logic [63:0] K_B   = 64'd971821376;
    localparam logic [63:0] K_C   = 64'd5127;
    localparam logic [63:0] K_RND = 64'd1 << 47;
    localparam longint DRIFT_CAP  = longint'(1) << 44;

    typedef struct packed {
        logic [255:0] tgt;
        logic         err;
    } t_target;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [63:0] i_ref_target_w0 = '0, i_ref_target_w1 = '0;
    logic [63:0] i_ref_target_w2 = '0, i_ref_target_w3 = '0;
    logic signed [32:0] i_time_diff = '0;
    logic [31:0] i_height_diff = '0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_addr = '0;
    logic [63:0] i_cfg_data = '0;
    logic o_valid;
    logic [63:0] o_next_target_w0, o_next_target_w1, o_next_target_w2, o_next_target_w3;
    logic o_input_error;

    always #5 i_clk = ~i_clk;

    asert_difficulty_target_top uut (.*);

    // Shadow copy of the configuration registers
    logic [255:0] pow_lim;
    logic [19:0]  spacing;
    logic [31:0]  hlife;

    t_target pending_targets[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int item_count = 0;
    bit quiet = 1'b0;       // no idling while set

    // Next target from anchor, time and height difference, current config
    function automatic t_target next_target(input logic [255:0] anchor,
                                            input logic signed [32:0] td,
                                            input logic [31:0] hd);
        longint drift, expo, shf, s;
        logic [63:0] frac, fac;
        logic [319:0] v;
        int bl;
        bit sat;
        t_target o;
        sat = 1'b0;
        o.err = 1'b0;
        if (anchor == '0 || anchor > pow_lim || hlife == '0) begin
            o.tgt = '0;
            o.err = 1'b1;
            return o;
        end
        drift = longint'(td) - $signed({44'b0, spacing}) * ($signed({32'b0, hd}) + 1);
        if (drift > DRIFT_CAP) drift = DRIFT_CAP;
        if (drift < -DRIFT_CAP) drift = -DRIFT_CAP;
        expo = (drift * 65536) / $signed({32'b0, hlife});
        shf = expo / 65536;
        if (expo % 65536 != 0 && expo < 0) shf = shf - 1;
        frac = expo - shf * 65536;
        // 64-bit wraparound is part of the definition
        fac = 64'd65536 + ((K_A * frac + K_B * frac * frac + K_C * frac * frac * frac
                            + K_RND) >> 48);
        v = {64'b0, anchor} * fac[16:0];
        s = shf - 16;
        if (s > 0) begin
            bl = 0;
            for (int i = 319; i >= 0; i--) begin
                if (v[i] && bl == 0) bl = i + 1;
            end
            if (longint'(bl) + s > 256) sat = 1'b1;
            else v = v << s;
        end else if (s < 0) begin
            if (s <= -320) v = '0;
            else v = v >> (-s);
        end
        if (v[319:256] != '0) sat = 1'b1;
        o.tgt = v[255:0];
        if (!sat) begin
            if (o.tgt == '0) o.tgt = 256'd1;
            else if (o.tgt > pow_lim) sat = 1'b1;
        end
        if (sat) o.tgt = pow_lim;
        return o;
    endfunction

    // Checker: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_target exp_t;
        if (i_rst_n && o_valid) begin
            if (pending_targets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                exp_t = pending_targets.pop_front();
                if (exp_t.tgt != {o_next_target_w3, o_next_target_w2,
                                  o_next_target_w1, o_next_target_w0}
                    || exp_t.err != o_input_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp err=%0b tgt=%h got err=%0b tgt=%h",
                                 exp_t.err, exp_t.tgt, o_input_error,
                                 {o_next_target_w3, o_next_target_w2,
                                  o_next_target_w1, o_next_target_w0});
                end
            end
        end
    end

    // Watchdog: cycles with neither side accepting a transaction
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("asert_difficulty_target_top test failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            asdt_pkg::CFG_POW_W0:  pow_lim[63:0]    = val;
            asdt_pkg::CFG_POW_W1:  pow_lim[127:64]  = val;
            asdt_pkg::CFG_POW_W2:  pow_lim[191:128] = val;
            asdt_pkg::CFG_POW_W3:  pow_lim[255:192] = val;
            asdt_pkg::CFG_SPACING: spacing          = val[19:0];
            asdt_pkg::CFG_HLIFE:   hlife            = val[31:0];
            default: ;
        endcase
    endtask

    // Drain the pipeline before touching configuration
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (asdt_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_pow(input logic [255:0] p);
        cfg_write(asdt_pkg::CFG_POW_W0, p[63:0]);
        cfg_write(asdt_pkg::CFG_POW_W1, p[127:64]);
        cfg_write(asdt_pkg::CFG_POW_W2, p[191:128]);
        cfg_write(asdt_pkg::CFG_POW_W3, p[255:192]);
    endtask

    // One input transaction; unless quiet is set, each cycle ahead of it idles at random
    task automatic send_item(input logic [255:0] anchor, input logic signed [32:0] td,
                             input logic [31:0] hd);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        {i_ref_target_w3, i_ref_target_w2, i_ref_target_w1, i_ref_target_w0} <= anchor;
        i_time_diff <= td;
        i_height_diff <= hd;
        do @(posedge i_clk); while (busy);
        pending_targets.push_back(next_target(anchor, td, hd));
        item_count++;
    endtask

    function automatic logic [255:0] rand256();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
    endfunction

    // Mostly valid anchors near realistic drift; some bad anchors and raw noise
    task automatic random_items(input int n);
        logic [255:0] anchor;
        logic [31:0] hd;
        longint nominal;
        for (int k = 0; k < n; k++) begin
            quiet = (item_count % 400) >= 300;
            case ($urandom_range(0, 9))
                0: anchor = '0;
                1: anchor = pow_lim + rand256() % 8 + 1;
                2: anchor = rand256();
                3: anchor = pow_lim;
                default: begin
                    anchor = rand256() >> $urandom_range(0, 255);
                    if (anchor > pow_lim) anchor = pow_lim >> $urandom_range(0, 255);
                    if (anchor == '0) anchor = 256'd1;
                end
            endcase
            hd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
            nominal = longint'(spacing) * (longint'(hd) + 1);
            if ($urandom_range(0, 3) == 0)
                send_item(anchor, {$urandom, 1'($urandom)}, hd);
            else
                send_item(anchor, 33'(nominal + $signed(longint'($urandom_range(0, 4000000)))
                                  - 2000000), hd);
        end
        quiet = 1'b0;
    endtask

    // Extremes of fields and the corner cases under default registers
    task automatic test_defaults();
        send_item(256'd1, 33'sd600, 32'd0);
        send_item(pow_lim, 33'sd0, 32'd0);
        send_item(pow_lim + 1, 33'sd600, 32'd0);              // anchor above limit
        send_item('0, 33'sd600, 32'd0);                       // zero anchor
        send_item('1, 33'sd600, 32'd0);
        send_item(pow_lim >> 8, 33'sh0_FFFF_FFFF, 32'd0);     // max time, large drift up
        send_item(pow_lim >> 8, 33'sh1_0000_0000, 32'd0);     // min time
        send_item(256'd12345, 33'sh1_0000_0000, 32'hFFFF_FFFF); // large drift down
        send_item(256'd1, -33'sd1000000, 32'd0);              // shifts to zero
        send_item(pow_lim >> 32, 33'sd700000, 32'd10);
        send_item(pow_lim >> 100, -33'sd90000, 32'd100);
        send_item(pow_lim >> 1, 33'sd600 + 33'sd172800, 32'd0); // exactly one half life
        send_item(256'd3, 33'sd599, 32'd0);                   // tiny negative drift
    endtask

    task automatic test_config_extremes();
        drain();
        set_pow('1);
        cfg_write(asdt_pkg::CFG_SPACING, 64'd1);
        cfg_write(asdt_pkg::CFG_HLIFE, 64'd1);
        send_item('1, 33'sd1, 32'd0);
        send_item('1, 33'sd5, 32'd0);                         // result beyond 2^256
        send_item(256'd1, 33'sh1_0000_0000, 32'hFFFF_FFFF);
        random_items(200);
        drain();
        cfg_write(asdt_pkg::CFG_SPACING, 64'hF_FFFF);
        cfg_write(asdt_pkg::CFG_HLIFE, 64'hFFFF_FFFF);
        send_item('1, 33'sh0_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(256'd7, 33'sh0_FFFF_FFFF, 32'd0);
        random_items(200);
    endtask

    task automatic test_zero_half_life();
        drain();
        cfg_write(asdt_pkg::CFG_HLIFE, 64'd0);
        send_item(256'd1, 33'sd600, 32'd0);
        random_items(60);
    endtask

    task automatic test_unused_index();
        drain();
        cfg_write(asdt_pkg::CFG_HLIFE, 64'hFFFF_FFFF_0002_A300);    // upper bits dropped
        cfg_write(asdt_pkg::CFG_SPACING, 64'hFFFF_FFFF_FFF0_0258);
        cfg_write(CFG_UNUSED_LO, 64'd0);
        cfg_write(CFG_UNUSED_HI, '1);
        set_pow({64'h0000_0000_FFFF_FFFF, {3{64'hFFFF_FFFF_FFFF_FFFF}}});
        random_items(200);
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_pow(rand256() >> $urandom_range(0, 200));
            cfg_write(asdt_pkg::CFG_SPACING, 64'($urandom_range(1, 20'hF_FFFF)));
            cfg_write(asdt_pkg::CFG_HLIFE,
                      (ph == 0) ? 64'd2 : 64'($urandom_range(1, 5000000)));
            random_items(240);
        end
    endtask

    initial begin
        pow_lim = {64'h0000_0000_FFFF_FFFF, {3{64'hFFFF_FFFF_FFFF_FFFF}}};
        spacing = 20'd600;
        hlife   = 32'd172800;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        random_items(220);
        test_config_extremes();
        test_zero_half_life();
        test_unused_index();
        test_random_configs();
        drain();
        if (mismatches == 0 && pending_targets.size() == 0) begin
            $display("asert_difficulty_target_top test passed");
        end else begin
            $display("asert_difficulty_target_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/asdt_pkg.sv
rtl/asdt_div.sv
rtl/asert_difficulty_target_top.sv
dv/asert_difficulty_target_top_tb.sv
